[rtl/core/iay_pkg.sv]
// iay_pkg: shared types and constants of the imu averager and yaw integrator
// used by every module in rtl/core; no dependencies of its own
`timescale 1ns / 1ps
`default_nettype none

package iay_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int CFG_W        = 15;
	localparam int DT_W         = 20;
	localparam int TGT_W        = 17;
	localparam int YAW_W        = 48;
	localparam int SCALE_W      = 26;
	localparam int TGT_SCALED_W = TGT_W + SCALE_W;
	localparam int RECIP_SHIFT  = 24;
	localparam int RECIP_W      = RECIP_SHIFT + 1;

	localparam logic [SCALE_W-1:0] TARGET_SCALE = SCALE_W'(65500000);

	localparam logic signed [YAW_W-1:0] YAW_MAX = {1'b0, {(YAW_W-1){1'b1}}};
	localparam logic signed [YAW_W-1:0] YAW_MIN = {1'b1, {(YAW_W-1){1'b0}}};

	localparam logic [CFG_W-1:0] COLLISION_LIMIT_RST = CFG_W'(4915);
	localparam logic [CFG_W-1:0] STRAIGHT_LIMIT_RST  = CFG_W'(131);

	localparam logic REG_COLLISION_LIMIT = 1'b0;
	localparam logic REG_STRAIGHT_LIMIT  = 1'b1;

	typedef enum logic [1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_YAW    = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
		logic adv_s3;
		logic item_s1;
	} pipe_ctl_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] accel_avg;
		logic signed [SAMPLE_W-1:0] gyro_avg;
		logic                       collision;
		logic                       straight;
	} avg_res_t;

endpackage

`default_nettype wire

[rtl/core/iay_cell.sv]
// iay_cell: one window cell holding an accel and a gyro sample
// shifts its pair on to the next cell on each sample item; uses iay_pkg
`timescale 1ns / 1ps
`default_nettype none

module iay_cell import iay_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       shift,
	input  wire logic signed [SAMPLE_W-1:0] accel_in,
	input  wire logic signed [SAMPLE_W-1:0] gyro_in,
	output logic signed [SAMPLE_W-1:0]      accel_out,
	output logic signed [SAMPLE_W-1:0]      gyro_out
);

	logic signed [SAMPLE_W-1:0] accel_q;
	logic signed [SAMPLE_W-1:0] gyro_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= '0;
			gyro_q  <= '0;
		end else if (shift) begin
			accel_q <= accel_in;
			gyro_q  <= gyro_in;
		end
	end

	assign accel_out = accel_q;
	assign gyro_out  = gyro_q;

endmodule

`default_nettype wire

[rtl/core/iay_window.sv]
// iay_window: chain of sample cells with running window sums
// depends on iay_pkg and iay_cell
`timescale 1ns / 1ps
`default_nettype none

module iay_window import iay_pkg::*; #(
	parameter int WINDOW_LEN = 5,
	parameter int SUM_W      = 19
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       shift,
	input  wire logic signed [SAMPLE_W-1:0] accel_raw,
	input  wire logic signed [SAMPLE_W-1:0] gyro_raw,
	output logic signed [SUM_W-1:0]         asum,
	output logic signed [SUM_W-1:0]         gsum
);

	logic signed [SAMPLE_W-1:0] a_tap [WINDOW_LEN+1];
	logic signed [SAMPLE_W-1:0] g_tap [WINDOW_LEN+1];
	logic signed [SUM_W-1:0]    asum_q;
	logic signed [SUM_W-1:0]    gsum_q;

	assign a_tap[0] = accel_raw;
	assign g_tap[0] = gyro_raw;

	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		iay_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (shift),
			.accel_in  (a_tap[i]),
			.gyro_in   (g_tap[i]),
			.accel_out (a_tap[i+1]),
			.gyro_out  (g_tap[i+1])
		);
	end

	// oldest sample leaves as the new one enters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asum_q <= '0;
			gsum_q <= '0;
		end else if (shift) begin
			asum_q <= asum_q + SUM_W'(accel_raw) - SUM_W'(a_tap[WINDOW_LEN]);
			gsum_q <= gsum_q + SUM_W'(gyro_raw) - SUM_W'(g_tap[WINDOW_LEN]);
		end
	end

	assign asum = asum_q;
	assign gsum = gsum_q;

endmodule

`default_nettype wire

[rtl/core/iay_avg.sv]
// iay_avg: window averages by reciprocal multiply, and collision/straight flags
// two stages (s2 divide, s3 sign and compare); depends on iay_pkg
`timescale 1ns / 1ps
`default_nettype none

module iay_avg import iay_pkg::*; #(
	parameter int WINDOW_LEN = 5,
	parameter int SUM_W      = 19
) (
	input  wire logic                    clk,
	input  wire pipe_ctl_t               ctl,
	input  wire logic signed [SUM_W-1:0] asum,
	input  wire logic signed [SUM_W-1:0] gsum,
	input  wire logic [CFG_W-1:0]        collision_limit,
	input  wire logic [CFG_W-1:0]        straight_limit,
	output avg_res_t                     res
);

	localparam int PROD_W = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((2 ** RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

	logic [SUM_W-1:0]    amag;
	logic [SUM_W-1:0]    gmag;
	logic [PROD_W-1:0]   aprod;
	logic [PROD_W-1:0]   gprod;
	logic [SAMPLE_W-1:0] amag_s2;
	logic [SAMPLE_W-1:0] gmag_s2;
	logic                aneg_s2;
	logic                gneg_s2;
	avg_res_t            res_q;

	always_comb begin
		amag  = asum[SUM_W-1] ? $unsigned(-asum) : $unsigned(asum);
		gmag  = gsum[SUM_W-1] ? $unsigned(-gsum) : $unsigned(gsum);
		aprod = PROD_W'(amag) * PROD_W'(RECIP);
		gprod = PROD_W'(gmag) * PROD_W'(RECIP);
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			amag_s2 <= aprod[RECIP_SHIFT +: SAMPLE_W];
			gmag_s2 <= gprod[RECIP_SHIFT +: SAMPLE_W];
			aneg_s2 <= asum[SUM_W-1];
			gneg_s2 <= gsum[SUM_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			res_q.accel_avg <= aneg_s2 ? -$signed(amag_s2) : $signed(amag_s2);
			res_q.gyro_avg  <= gneg_s2 ? -$signed(gmag_s2) : $signed(gmag_s2);
			res_q.collision <= amag_s2 > SAMPLE_W'(collision_limit);
			res_q.straight  <= gmag_s2 < SAMPLE_W'(straight_limit);
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

[rtl/core/iay_yaw.sv]
// iay_yaw: yaw multiply-accumulate with saturation and turn target check
// s1 multiply, s2 accumulate, s3 compare; depends on iay_pkg
`timescale 1ns / 1ps
`default_nettype none

module iay_yaw import iay_pkg::*; #(
	parameter int SUM_W = 19
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire pipe_ctl_t               ctl,
	input  wire logic signed [SUM_W-1:0] gsum,
	input  wire logic [1:0]              mode,
	input  wire logic [DT_W-1:0]         elapsed_us,
	input  wire logic signed [TGT_W-1:0] target_angle,
	output logic signed [YAW_W-1:0]      yaw_total,
	output logic                         turn_done
);

	localparam int PROD_W = SUM_W + DT_W + 1;

	logic signed [PROD_W-1:0]  prod_s1;
	logic [TGT_W-1:0]          tmag_s1;
	mode_t                     mode_s1;
	logic [TGT_W-1:0]          tmag;
	logic [TGT_SCALED_W-1:0]   tscale_s2;
	logic                      chk_s2;
	logic signed [YAW_W-1:0]   yaw_q;
	logic signed [YAW_W:0]     yaw_sum;
	logic signed [YAW_W-1:0]   yaw_next;
	logic [YAW_W-1:0]          ymag;
	logic signed [YAW_W-1:0]   yaw_total_q;
	logic                      turn_done_q;

	assign tmag = target_angle[TGT_W-1] ? $unsigned(-target_angle) : $unsigned(target_angle);

	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			prod_s1 <= PROD_W'(gsum) * PROD_W'($signed({1'b0, elapsed_us}));
			tmag_s1 <= tmag;
			mode_s1 <= mode_t'(mode);
		end
	end

	always_comb begin
		yaw_sum = (YAW_W+1)'(yaw_q) + (YAW_W+1)'(prod_s1);
		case (mode_s1)
			MODE_YAW: begin
				if (yaw_sum[YAW_W] != yaw_sum[YAW_W-1])
					yaw_next = yaw_sum[YAW_W] ? YAW_MIN : YAW_MAX;
				else
					yaw_next = yaw_sum[YAW_W-1:0];
			end
			MODE_CLEAR: yaw_next = '0;
			default:    yaw_next = yaw_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q <= '0;
		end else if (ctl.adv_s2 && ctl.item_s1) begin
			yaw_q <= yaw_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			tscale_s2 <= TGT_SCALED_W'(tmag_s1) * TGT_SCALED_W'(TARGET_SCALE);
			chk_s2    <= (mode_s1 == MODE_YAW);
		end
	end

	assign ymag = yaw_q[YAW_W-1] ? $unsigned(-yaw_q) : $unsigned(yaw_q);

	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			yaw_total_q <= yaw_q;
			turn_done_q <= chk_s2 && (ymag >= YAW_W'(tscale_s2));
		end
	end

	assign yaw_total = yaw_total_q;
	assign turn_done = turn_done_q;

endmodule

`default_nettype wire

[rtl/core/imu_average_and_yaw_integrator.sv]
// imu_average_and_yaw_integrator: top level, handshake, config registers, pipeline control
// depends on iay_pkg, iay_window, iay_avg, iay_yaw
//
// channel   direction  handshake               payload
// in        sink       in_valid / in_ready     mode, accel_raw, gyro_raw, elapsed_us, target_angle
// out       source     out_valid / out_ready   accel_avg, gyro_avg, collision, straight,
//                                              yaw_total, turn_done
// cfg       sink       cfg_we                  cfg_index, cfg_wdata
//
// one item per cycle sustained while out_ready holds; each item passes stages s1, s2 and s3 before its result is shown
// window cells and sums update at acceptance of a sample item, yaw accumulates in stage two
// each stage moves when the next one is empty or moving, so bubbles are filled
// reset clears windows, sums, yaw and valid bits and loads the limit defaults
`timescale 1ns / 1ps
`default_nettype none

module imu_average_and_yaw_integrator import iay_pkg::*; #(
	parameter int WINDOW_LEN = 5
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [CFG_W-1:0]           cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 mode,
	input  wire logic signed [SAMPLE_W-1:0] accel_raw,
	input  wire logic signed [SAMPLE_W-1:0] gyro_raw,
	input  wire logic [DT_W-1:0]            elapsed_us,
	input  wire logic signed [TGT_W-1:0]    target_angle,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      accel_avg,
	output logic signed [SAMPLE_W-1:0]      gyro_avg,
	output logic                            collision,
	output logic                            straight,
	output logic signed [YAW_W-1:0]         yaw_total,
	output logic                            turn_done
);

	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN);

	logic [CFG_W-1:0]        collision_limit_q;
	logic [CFG_W-1:0]        straight_limit_q;
	logic                    v_s1;
	logic                    v_s2;
	logic                    v_s3;
	pipe_ctl_t               ctl;
	logic                    shift;
	logic signed [SUM_W-1:0] asum;
	logic signed [SUM_W-1:0] gsum;
	avg_res_t                avg_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collision_limit_q <= COLLISION_LIMIT_RST;
			straight_limit_q  <= STRAIGHT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLLISION_LIMIT: collision_limit_q <= cfg_wdata;
				REG_STRAIGHT_LIMIT:  straight_limit_q  <= cfg_wdata;
			endcase
		end
	end

	always_comb begin
		ctl.adv_s3  = !v_s3 || out_ready;
		ctl.adv_s2  = !v_s2 || ctl.adv_s3;
		ctl.adv_s1  = !v_s1 || ctl.adv_s2;
		ctl.item_s1 = v_s1;
	end

	assign in_ready = ctl.adv_s1;
	assign shift    = in_valid && in_ready && (mode == MODE_SAMPLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ctl.adv_s1)
				v_s1 <= in_valid;
			if (ctl.adv_s2)
				v_s2 <= v_s1;
			if (ctl.adv_s3)
				v_s3 <= v_s2;
		end
	end

	iay_window #(
		.WINDOW_LEN (WINDOW_LEN),
		.SUM_W      (SUM_W)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (shift),
		.accel_raw (accel_raw),
		.gyro_raw  (gyro_raw),
		.asum      (asum),
		.gsum      (gsum)
	);

	iay_avg #(
		.WINDOW_LEN (WINDOW_LEN),
		.SUM_W      (SUM_W)
	) u_avg (
		.clk             (clk),
		.ctl             (ctl),
		.asum            (asum),
		.gsum            (gsum),
		.collision_limit (collision_limit_q),
		.straight_limit  (straight_limit_q),
		.res             (avg_res)
	);

	iay_yaw #(
		.SUM_W (SUM_W)
	) u_yaw (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.gsum         (gsum),
		.mode         (mode),
		.elapsed_us   (elapsed_us),
		.target_angle (target_angle),
		.yaw_total    (yaw_total),
		.turn_done    (turn_done)
	);

	assign out_valid = v_s3;
	assign accel_avg = avg_res.accel_avg;
	assign gyro_avg  = avg_res.gyro_avg;
	assign collision = avg_res.collision;
	assign straight  = avg_res.straight;

	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !ctl.adv_s2) |-> !in_ready)
		else $error("item accepted while stage one is held");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted item missing from stage one");

	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s2))
		else $error("result shown without an item in stage two");

endmodule

`default_nettype wire

[bench/imu_average_and_yaw_integrator_tb.sv]
// imu_average_and_yaw_integrator_tb: self-checking bench for the imu averager and yaw integrator
// a stimulus table, then random bursts and a yaw saturation run, all checked in order
// depends on iay_pkg and imu_average_and_yaw_integrator
`timescale 1ns / 1ps

module imu_average_and_yaw_integrator_tb;
	import iay_pkg::*;

	localparam int     CLK_PERIOD  = 20;
	localparam int     WIN         = 5;
	localparam int     PIPE_LAT    = 3;
	localparam int     QUIET_LIMIT = 1000;
	localparam int     N_DIRECTED  = 24;
	localparam longint TGT_SCALE   = 65500000;
	localparam longint YAW_TOP     = (longint'(1) <<< (YAW_W - 1)) - 1;
	localparam longint YAW_BOTTOM  = -YAW_TOP - 1;

	typedef struct {
		mode_t                      mode;
		logic signed [SAMPLE_W-1:0] accel;
		logic signed [SAMPLE_W-1:0] gyro;
		logic [DT_W-1:0]            dt;
		logic signed [TGT_W-1:0]    tgt;
	} imu_item_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] accel_avg;
		logic signed [SAMPLE_W-1:0] gyro_avg;
		logic                       collision;
		logic                       straight;
		logic signed [YAW_W-1:0]    yaw_total;
		logic                       turn_done;
	} imu_result_t;

	typedef struct {
		mode_t  mode;
		int     accel;
		int     gyro;
		int     dt;
		int     tgt;
		bit     typed;
		int     aavg;
		int     gavg;
		bit     col;
		bit     str;
		longint yaw;
		bit     done;
	} stim_row_t;

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       cfg_we       = 1'b0;
	logic                       cfg_index    = REG_COLLISION_LIMIT;
	logic [CFG_W-1:0]           cfg_wdata    = '0;
	logic                       in_valid     = 1'b0;
	logic                       in_ready;
	logic [1:0]                 mode         = MODE_SAMPLE;
	logic signed [SAMPLE_W-1:0] accel_raw    = '0;
	logic signed [SAMPLE_W-1:0] gyro_raw     = '0;
	logic [DT_W-1:0]            elapsed_us   = '0;
	logic signed [TGT_W-1:0]    target_angle = '0;
	logic                       out_valid;
	logic                       out_ready    = 1'b0;
	logic signed [SAMPLE_W-1:0] accel_avg;
	logic signed [SAMPLE_W-1:0] gyro_avg;
	logic                       collision;
	logic                       straight;
	logic signed [YAW_W-1:0]    yaw_total;
	logic                       turn_done;

	// predicted block state
	logic signed [SAMPLE_W-1:0] accel_hist [WIN];
	logic signed [SAMPLE_W-1:0] gyro_hist [WIN];
	longint                     gyro_total;
	longint                     yaw_acc;
	logic [CFG_W-1:0]           coll_lim;
	logic [CFG_W-1:0]           str_lim;

	imu_result_t pending_outputs [$];
	imu_result_t want;
	int          fails        = 0;
	int          items_sent   = 0;
	int          quiet_cycles = 0;
	bit          in_idle_en   = 1'b1;
	bit          out_idle_en  = 1'b1;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{MODE_NONE,   0,      0,      0,       0,      1'b1, 0,      0,      1'b0, 1'b1, 0, 1'b0},
		'{MODE_YAW,    0,      0,      1048575, 0,      1'b1, 0,      0,      1'b0, 1'b1, 0, 1'b1},
		'{MODE_CLEAR,  -1,     -1,     1048575, -1,     1'b1, 0,      0,      1'b0, 1'b1, 0, 1'b0},
		'{MODE_SAMPLE, 32767,  32767,  0,       0,      1'b1, 6553,   6553,   1'b1, 1'b0, 0, 1'b0},
		'{MODE_SAMPLE, -32768, -32768, 0,       0,      1'b1, 0,      0,      1'b0, 1'b1, 0, 1'b0},
		'{MODE_SAMPLE, 32767,  32767,  1048575, 36000,  1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_SAMPLE, 32767,  32767,  0,       0,      1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_SAMPLE, 32767,  32767,  0,       0,      1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_SAMPLE, 32767,  32767,  0,       0,      1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_SAMPLE, 32767,  32767,  0,       0,      1'b1, 32767,  32767,  1'b1, 1'b0, 0, 1'b0},
		'{MODE_YAW,    -32768, 12345,  1048575, 36000,  1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_YAW,    100,    -100,   0,       -36000, 1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_YAW,    0,      0,      1,       1,      1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_NONE,   -1,     -1,     1048575, -36000, 1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_CLEAR,  21845,  -21846, 699050,  -1,     1'b1, 32767,  32767,  1'b1, 1'b0, 0, 1'b0},
		'{MODE_SAMPLE, -32768, -32768, 0,       0,      1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_SAMPLE, -32768, -32768, 0,       0,      1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_SAMPLE, -32768, -32768, 0,       0,      1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_SAMPLE, -32768, -32768, 0,       0,      1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_SAMPLE, -32768, -32768, 0,       0,      1'b1, -32768, -32768, 1'b1, 1'b0, 0, 1'b0},
		'{MODE_YAW,    0,      0,      1048575, -1,     1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_SAMPLE, 0,      130,    0,       0,      1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_YAW,    0,      0,      0,       0,      1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0},
		'{MODE_SAMPLE, 16384,  -131,   0,       0,      1'b0, 0,      0,      1'b0, 1'b0, 0, 1'b0}
	};

	imu_average_and_yaw_integrator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.accel_raw    (accel_raw),
		.gyro_raw     (gyro_raw),
		.elapsed_us   (elapsed_us),
		.target_angle (target_angle),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accel_avg    (accel_avg),
		.gyro_avg     (gyro_avg),
		.collision    (collision),
		.straight     (straight),
		.yaw_total    (yaw_total),
		.turn_done    (turn_done)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clip16(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic imu_result_t step_avg_yaw(imu_item_t it);
		imu_result_t r;
		longint      asum;
		longint      aavg;
		longint      gavg;
		longint      y;
		int          i;
		asum = 0;
		r.turn_done = 1'b0;
		case (it.mode)
			MODE_SAMPLE: begin
				for (i = WIN - 1; i > 0; i--) begin
					accel_hist[i] = accel_hist[i - 1];
					gyro_hist[i] = gyro_hist[i - 1];
				end
				accel_hist[0] = it.accel;
				gyro_hist[0] = it.gyro;
				gyro_total = 0;
				for (i = 0; i < WIN; i++)
					gyro_total += gyro_hist[i];
			end
			MODE_YAW: begin
				y = yaw_acc + gyro_total * longint'(it.dt);
				if (y > YAW_TOP)
					y = YAW_TOP;
				if (y < YAW_BOTTOM)
					y = YAW_BOTTOM;
				yaw_acc = y;
				r.turn_done = magnitude(yaw_acc) >= magnitude(longint'(it.tgt)) * TGT_SCALE;
			end
			MODE_CLEAR: yaw_acc = 0;
			default: ;
		endcase
		for (i = 0; i < WIN; i++)
			asum += accel_hist[i];
		aavg = asum / WIN;
		gavg = gyro_total / WIN;
		r.accel_avg = aavg[SAMPLE_W-1:0];
		r.gyro_avg = gavg[SAMPLE_W-1:0];
		r.collision = magnitude(aavg) > longint'(coll_lim);
		r.straight = magnitude(gavg) < longint'(str_lim);
		r.yaw_total = yaw_acc[YAW_W-1:0];
		return r;
	endfunction

	function automatic imu_item_t rand_item();
		imu_item_t it;
		int        p;
		p = $urandom_range(99);
		if (p < 50)
			it.mode = MODE_SAMPLE;
		else if (p < 80)
			it.mode = MODE_YAW;
		else if (p < 90)
			it.mode = MODE_CLEAR;
		else
			it.mode = MODE_NONE;
		it.accel = SAMPLE_W'($urandom);
		it.gyro = SAMPLE_W'($urandom);
		it.dt = DT_W'($urandom);
		it.tgt = TGT_W'(int'($urandom_range(72000)) - 36000);
		return it;
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] exp_v,
			input logic signed [63:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fails++;
		end
	endtask

	// valid stays high between back-to-back items, it only drops in a gap
	task automatic offer_item(input imu_item_t it, output imu_result_t pred);
		while (in_idle_en && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.mode;
		accel_raw <= it.accel;
		gyro_raw <= it.gyro;
		elapsed_us <= it.dt;
		target_angle <= it.tgt;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		items_sent++;
		pred = step_avg_yaw(it);
	endtask

	task automatic offer_checked(input imu_item_t it);
		imu_result_t pred;
		offer_item(it, pred);
		pending_outputs.push_back(pred);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	task automatic write_limits(input logic [CFG_W-1:0] coll, input logic [CFG_W-1:0] strl);
		cfg_we <= 1'b1;
		cfg_index <= REG_COLLISION_LIMIT;
		cfg_wdata <= coll;
		@(posedge clk);
		cfg_index <= REG_STRAIGHT_LIMIT;
		cfg_wdata <= strl;
		@(posedge clk);
		cfg_we <= 1'b0;
		coll_lim = coll;
		str_lim = strl;
	endtask

	task automatic random_phase(input int n);
		imu_item_t it;
		int        stop;
		int        k;
		int        reps;
		int        sa;
		int        sg;
		int        va;
		int        vg;
		int        tm;
		longint    nxt;
		stop = items_sent + n;
		while (items_sent < stop) begin
			case ($urandom_range(9))
				0, 1, 2, 3: offer_checked(rand_item());
				4, 5, 6: begin
					// fill the windows around the limits, one odd sample for truncation
					sa = $urandom_range(1) ? -1 : 1;
					sg = $urandom_range(1) ? -1 : 1;
					va = sa * (int'(coll_lim) + int'($urandom_range(2)) - 1);
					vg = sg * (int'(str_lim) + int'($urandom_range(2)) - 1);
					for (k = 0; k < WIN; k++) begin
						it = rand_item();
						it.mode = MODE_SAMPLE;
						it.accel = SAMPLE_W'(clip16(clip16(va) +
							((k == 0) ? int'($urandom_range(8)) - 4 : 0)));
						it.gyro = SAMPLE_W'(clip16(clip16(vg) +
							((k == 0) ? int'($urandom_range(8)) - 4 : 0)));
						offer_checked(it);
					end
				end
				7, 8: begin
					reps = $urandom_range(4, 1);
					for (k = 0; k < reps; k++) begin
						it = rand_item();
						it.mode = MODE_YAW;
						case ($urandom_range(3))
							0: it.dt = '0;
							1: it.dt = DT_W'($urandom_range(1000, 1));
							default: it.dt = DT_W'($urandom);
						endcase
						if ($urandom_range(1)) begin
							// aim the target at the coming yaw so turn_done goes both ways
							nxt = yaw_acc + gyro_total * longint'(it.dt);
							tm = int'(magnitude(nxt) / TGT_SCALE) + int'($urandom_range(2)) - 1;
							if (tm < 0)
								tm = 0;
							if (tm > 36000)
								tm = 36000;
							it.tgt = TGT_W'($urandom_range(1) ? -tm : tm);
						end
						offer_checked(it);
					end
				end
				default: begin
					it = rand_item();
					it.mode = $urandom_range(1) ? MODE_CLEAR : MODE_NONE;
					offer_checked(it);
				end
			endcase
		end
	endtask

	// full-rate gyro window, then long yaw steps until the accumulator pins
	task automatic yaw_saturate(input int rate);
		imu_item_t it;
		int        k;
		int        hits;
		for (k = 0; k < WIN; k++) begin
			it = rand_item();
			it.mode = MODE_SAMPLE;
			it.gyro = SAMPLE_W'(rate);
			offer_checked(it);
		end
		hits = 0;
		while (hits < 3) begin
			it = rand_item();
			if ($urandom_range(49) == 0) begin
				it.mode = MODE_NONE;
			end else begin
				it.mode = MODE_YAW;
				it.dt = DT_W'($urandom_range(1048575, 1040000));
			end
			offer_checked(it);
			if (yaw_acc == YAW_TOP || yaw_acc == YAW_BOTTOM)
				hits++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_outputs.size() == 0) begin
				$error("result item with nothing expected");
				fails++;
			end else begin
				want = pending_outputs.pop_front();
				check_field("accel_avg", want.accel_avg, accel_avg);
				check_field("gyro_avg", want.gyro_avg, gyro_avg);
				check_field("collision", want.collision, collision);
				check_field("straight", want.straight, straight);
				check_field("yaw_total", want.yaw_total, yaw_total);
				check_field("turn_done", want.turn_done, turn_done);
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		out_ready <= !out_idle_en || ($urandom_range(99) >= 26);
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		imu_item_t   it;
		imu_result_t pred;
		imu_result_t typed_res;
		stim_row_t   row;
		int          r;
		for (r = 0; r < WIN; r++) begin
			accel_hist[r] = '0;
			gyro_hist[r] = '0;
		end
		gyro_total = 0;
		yaw_acc = 0;
		coll_lim = COLLISION_LIMIT_RST;
		str_lim = STRAIGHT_LIMIT_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < N_DIRECTED; r++) begin
			row = directed_rows[r];
			it.mode = row.mode;
			it.accel = SAMPLE_W'(row.accel);
			it.gyro = SAMPLE_W'(row.gyro);
			it.dt = DT_W'(row.dt);
			it.tgt = TGT_W'(row.tgt);
			offer_item(it, pred);
			if (row.typed) begin
				typed_res.accel_avg = SAMPLE_W'(row.aavg);
				typed_res.gyro_avg = SAMPLE_W'(row.gavg);
				typed_res.collision = row.col;
				typed_res.straight = row.str;
				typed_res.yaw_total = YAW_W'(row.yaw);
				typed_res.turn_done = row.done;
				pending_outputs.push_back(typed_res);
			end else begin
				pending_outputs.push_back(pred);
			end
		end

		settle();
		write_limits('0, '0);
		random_phase(20);
		settle();
		write_limits('1, '1);
		random_phase(20);
		settle();
		in_idle_en = 1'b0;
		out_idle_en = 1'b0;
		write_limits(CFG_W'($urandom_range(32767)), CFG_W'($urandom_range(32767)));
		random_phase(40);
		settle();
		in_idle_en = 1'b1;
		out_idle_en = 1'b1;
		write_limits(CFG_W'($urandom_range(7000)), CFG_W'($urandom_range(1500)));
		yaw_saturate(32767);
		it = rand_item();
		it.mode = MODE_CLEAR;
		offer_checked(it);
		settle();

		if (fails == 0 && pending_outputs.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
